// ===== rtl/core/plr_pkg.sv =====
package plr_pkg;

    localparam int MASK_W = 16;

    // configuration register indexes
    localparam logic [1:0] REG_SQUARE_ORDER   = 2'd0;
    localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd1;
    localparam logic [1:0] REG_ROWS_IN_USE    = 2'd2;
    localparam logic [1:0] REG_DIAGONAL_MODE  = 2'd3;

    localparam logic [4:0] RST_SQUARE_ORDER   = 5'd10;
    localparam logic [4:0] RST_COLUMNS_IN_USE = 5'd10;
    localparam logic [3:0] RST_ROWS_IN_USE    = 4'd2;

    // failure codes
    localparam logic [2:0] FAIL_NONE   = 3'd0;
    localparam logic [2:0] FAIL_ROW    = 3'd1;
    localparam logic [2:0] FAIL_COLUMN = 3'd2;
    localparam logic [2:0] FAIL_MAIN   = 3'd3;
    localparam logic [2:0] FAIL_SEC    = 3'd4;
    localparam logic [2:0] FAIL_COUNT  = 3'd5;

    typedef struct packed {
        logic [3:0] cell_value;
        logic       last_cell;
    } t_in_word;

    typedef struct packed {
        logic       candidate_valid;
        logic [2:0] failure_code;
        logic [7:0] failure_position;
    } t_out_word;

    // one cell as handed from the sequencer to the check stage
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       in_range;
        logic [3:0] value;
        logic       on_main;
        logic       on_sec;
        logic       row_end;
        logic       cnt_ok;
        logic [7:0] here;
    } t_plr_cell;

endpackage

// ===== rtl/core/plr_ram.sv =====
module plr_ram
    #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
    )
    (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/plr_seq.sv =====
module plr_seq
    import plr_pkg::*;
    #(
    parameter int MAX_ORDER = 16,
    parameter int MAX_ROWS  = 16
    )
    (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [4:0]                   i_cfg_data,
    input  logic                         i_in_valid,
    input  t_in_word                     i_in_word,
    input  logic                         i_en,
    output logic                         o_accept,
    output logic [$clog2(MAX_ORDER)-1:0] o_rd_addr,
    output t_plr_cell                    o_s1,
    output logic [$clog2(MAX_ORDER)-1:0] o_s1_col,
    output logic [MASK_W-1:0]            o_sec_seed
    );

    localparam int         CW      = $clog2(MAX_ORDER);
    localparam logic [4:0] ORD_MAX = 5'(MAX_ORDER);
    localparam logic [3:0] ROW_MAX = 4'(MAX_ROWS - 1);

    logic [4:0]    r_order, r_cols_cfg;
    logic [3:0]    r_rows_cfg;
    logic          r_dmode;
    logic [CW-1:0] r_col, n_col;
    logic [3:0]    r_row, n_row;
    logic [7:0]    r_cells, n_cells;
    t_plr_cell     r_s1, n_s1;
    logic [CW-1:0] r_s1_col;

    logic [4:0] eff_n, eff_c, r5, c5;
    logic [3:0] eff_r;
    logic [8:0] prod;
    logic [7:0] expected, cells_inc;
    logic       accept, in_range, row_end;

    always_comb begin
        if (r_order < 5'd2)        eff_n = 5'd2;
        else if (r_order > ORD_MAX) eff_n = ORD_MAX;
        else                        eff_n = r_order;
        if (r_cols_cfg < 5'd1)      eff_c = 5'd1;
        else if (r_cols_cfg > eff_n) eff_c = eff_n;
        else                        eff_c = r_cols_cfg;
        if (r_rows_cfg < 4'd1)      eff_r = 4'd1;
        else if (r_rows_cfg > ROW_MAX) eff_r = ROW_MAX;
        else                        eff_r = r_rows_cfg;
    end

    assign prod      = 9'(eff_r) * 9'(eff_c);
    assign expected  = prod[7:0];
    assign accept    = i_in_valid && i_en;
    assign in_range  = r_cells < expected;
    assign r5        = {1'b0, r_row} + 5'd1;
    assign c5        = 5'(r_col);
    assign row_end   = (c5 + 5'd1) >= eff_c;
    assign cells_inc = (r_cells == 8'hFF) ? 8'hFF : r_cells + 8'd1;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_cells = r_cells;
        if (i_cfg_we) begin
            n_col   = '0;
            n_row   = '0;
            n_cells = '0;
        end else if (accept) begin
            if (i_in_word.last_cell) begin
                n_col   = '0;
                n_row   = '0;
                n_cells = '0;
            end else begin
                n_cells = cells_inc;
                if (in_range) begin
                    if (row_end) begin
                        n_col = '0;
                        n_row = r_row + 4'd1;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
        end

        n_s1.valid    = accept;
        n_s1.last     = i_in_word.last_cell;
        n_s1.in_range = in_range;
        n_s1.value    = i_in_word.cell_value;
        n_s1.on_main  = r_dmode && (c5 == r5);
        n_s1.on_sec   = r_dmode && (r5 <= eff_n - 5'd1) && (c5 == eff_n - 5'd1 - r5);
        n_s1.row_end  = row_end;
        n_s1.cnt_ok   = cells_inc == expected;
        n_s1.here     = r_cells;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= RST_SQUARE_ORDER;
            r_cols_cfg <= RST_COLUMNS_IN_USE;
            r_rows_cfg <= RST_ROWS_IN_USE;
            r_dmode    <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_cells    <= '0;
            r_s1.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SQUARE_ORDER:   r_order    <= i_cfg_data;
                    REG_COLUMNS_IN_USE: r_cols_cfg <= i_cfg_data;
                    REG_ROWS_IN_USE:    r_rows_cfg <= i_cfg_data[3:0];
                    REG_DIAGONAL_MODE:  r_dmode    <= i_cfg_data[0];
                    default:            r_dmode    <= r_dmode;
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_cells <= n_cells;
            if (i_en) begin
                r_s1 <= n_s1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_col <= r_col;
        end
    end

    assign o_accept   = accept;
    assign o_rd_addr  = r_col;
    assign o_s1       = r_s1;
    assign o_s1_col   = r_s1_col;
    assign o_sec_seed = MASK_W'(1) << 4'(eff_n - 5'd1);

endmodule

// ===== rtl/core/plr_eval.sv =====
module plr_eval
    import plr_pkg::*;
    #(
    parameter int MAX_ORDER = 16
    )
    (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_restart,
    input  logic                         i_s0_accept,
    input  logic                         i_s0_last,
    input  logic [$clog2(MAX_ORDER)-1:0] i_rd_addr,
    input  t_plr_cell                    i_s1,
    input  logic [$clog2(MAX_ORDER)-1:0] i_s1_col,
    input  logic [MASK_W-1:0]            i_sec_seed,
    input  logic [MASK_W-1:0]            i_ram_q,
    output logic                         o_we,
    output logic [$clog2(MAX_ORDER)-1:0] o_waddr,
    output logic [MASK_W-1:0]            o_wdata,
    output logic                         o_res_load,
    output t_out_word                    o_res
    );

    logic [MAX_ORDER-1:0] r_vld;
    logic                 r_vld_s1;
    logic                 r_fwd_hit;
    logic [MASK_W-1:0]    r_fwd_data;
    logic [MASK_W-1:0]    r_row, r_main, r_sec;
    logic                 r_sec_dirty;
    logic [2:0]           r_ff;
    logic [7:0]           r_fi;

    logic              act, chk;
    logic [MASK_W-1:0] bit_v, col_seed, col_mask, sec_mask;
    logic [2:0]        code, ff_new, fin_code;
    logic [7:0]        fi_new, fin_idx;

    assign act      = i_en && i_s1.valid;
    assign chk      = act && i_s1.in_range;
    assign bit_v    = MASK_W'(1) << i_s1.value;
    assign col_seed = MASK_W'(1) << i_s1_col;
    // same-column write from the cell just ahead wins over the stale RAM word
    assign col_mask = r_fwd_hit ? r_fwd_data : (r_vld_s1 ? i_ram_q : col_seed);
    assign sec_mask = r_sec_dirty ? r_sec : i_sec_seed;

    always_comb begin
        code = FAIL_NONE;
        if (i_s1.in_range) begin
            if ((r_row & bit_v) != '0)                        code = FAIL_ROW;
            else if ((col_mask & bit_v) != '0)                code = FAIL_COLUMN;
            else if (i_s1.on_main && (r_main & bit_v) != '0)  code = FAIL_MAIN;
            else if (i_s1.on_sec && (sec_mask & bit_v) != '0) code = FAIL_SEC;
        end
        if (r_ff == FAIL_NONE && code != FAIL_NONE) begin
            ff_new = code;
            fi_new = i_s1.here;
        end else begin
            ff_new = r_ff;
            fi_new = r_fi;
        end
        if (ff_new != FAIL_NONE) begin
            fin_code = ff_new;
            fin_idx  = fi_new;
        end else if (!i_s1.cnt_ok) begin
            fin_code = FAIL_COUNT;
            fin_idx  = i_s1.here;
        end else begin
            fin_code = FAIL_NONE;
            fin_idx  = '0;
        end
    end

    assign o_we    = chk && !i_s1.last;
    assign o_waddr = i_s1_col;
    assign o_wdata = col_mask | bit_v;

    assign o_res_load             = act && i_s1.last;
    assign o_res.candidate_valid  = fin_code == FAIL_NONE;
    assign o_res.failure_code     = fin_code;
    assign o_res.failure_position = fin_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_vld_s1    <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_row       <= '0;
            r_main      <= MASK_W'(1);
            r_sec_dirty <= 1'b0;
            r_ff        <= FAIL_NONE;
            r_fi        <= '0;
        end else begin
            if (i_restart || (i_s0_accept && i_s0_last)) begin
                r_vld <= '0;
            end else if (o_we) begin
                r_vld[i_s1_col] <= 1'b1;
            end
            if (i_en) begin
                r_vld_s1  <= r_vld[i_rd_addr];
                r_fwd_hit <= o_we && (i_rd_addr == i_s1_col);
            end
            if (i_restart || o_res_load) begin
                r_row       <= '0;
                r_main      <= MASK_W'(1);
                r_sec_dirty <= 1'b0;
                r_ff        <= FAIL_NONE;
                r_fi        <= '0;
            end else if (chk) begin
                r_row <= i_s1.row_end ? '0 : (r_row | bit_v);
                if (i_s1.on_main) begin
                    r_main <= r_main | bit_v;
                end
                if (i_s1.on_sec) begin
                    r_sec_dirty <= 1'b1;
                end
                r_ff <= ff_new;
                r_fi <= fi_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_data <= o_wdata;
        end
        if (chk && i_s1.on_sec) begin
            r_sec <= sec_mask | bit_v;
        end
    end

endmodule

// ===== rtl/core/partial_latin_rows_checker.sv =====
// A last cell is registered in stage 1, then its verdict in the verdict output register.
// One cell word per clock while o_in_stall is low; the column bitmap RAM is read at accept
//   and written back from stage 1, with a bypass for back-to-back hits on one column.
// A waiting verdict word held by i_out_stall freezes the two-stage pipe and raises o_in_stall.
// Reset (i_rst_n low, synchronous): registers take their reset settings and the
//   candidate state is re-seeded; no clearing pass, column valid bits clear at once.
module partial_latin_rows_checker
    import plr_pkg::*;
    #(
    parameter int MAX_ORDER = 16,
    parameter int MAX_ROWS  = 16
    )
    (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data,
    // cell word input
    input  logic       i_in_valid,
    input  t_in_word   i_in_word,
    output logic       o_in_stall,
    // verdict word output
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_stall
    );

    localparam int CW = $clog2(MAX_ORDER);

    logic              en;
    logic              accept;
    logic [CW-1:0]     rd_addr, s1_col, waddr;
    t_plr_cell         s1;
    logic [MASK_W-1:0] sec_seed, ram_q, wdata;
    logic              we, res_load;
    t_out_word         res;

    logic      r_out_valid;
    t_out_word r_out_word;

    // pipe advances whenever the verdict register is empty or being drained
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage 0: config registers, cell/row/column counters, RAM read issue
    plr_seq #(
        .MAX_ORDER (MAX_ORDER),
        .MAX_ROWS  (MAX_ROWS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_en       (en),
        .o_accept   (accept),
        .o_rd_addr  (rd_addr),
        .o_s1       (s1),
        .o_s1_col   (s1_col),
        .o_sec_seed (sec_seed)
    );

    // column seen bitmaps, one word per column
    plr_ram #(
        .WIDTH (MASK_W),
        .DEPTH (MAX_ORDER)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // stage 1: bitmap checks, write-back, first-failure tracking
    plr_eval #(
        .MAX_ORDER (MAX_ORDER)
    ) u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_restart   (i_cfg_we),
        .i_s0_accept (accept),
        .i_s0_last   (i_in_word.last_cell),
        .i_rd_addr   (rd_addr),
        .i_s1        (s1),
        .i_s1_col    (s1_col),
        .i_sec_seed  (sec_seed),
        .i_ram_q     (ram_q),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_res_load  (res_load),
        .o_res       (res)
    );

    // verdict output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/core/plr_checker.sv =====
module plr_checker
    import plr_pkg::*;
    (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input t_out_word  o_out_word,
    input logic       i_out_stall
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("verdict word changed while stalled");

    a_valid_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.candidate_valid |->
            o_out_word.failure_code == FAIL_NONE && o_out_word.failure_position == 8'd0)
        else $error("valid verdict carries a failure");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.candidate_valid |->
            o_out_word.failure_code >= FAIL_ROW && o_out_word.failure_code <= FAIL_COUNT)
        else $error("invalid verdict without a failure code");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("input taken while verdict register is blocked");

endmodule

bind partial_latin_rows_checker plr_checker u_plr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

// ===== verif/partial_latin_rows_checker_tb.sv =====
`timescale 1ns / 100ps

localparam int ORDER_CAP = 16;
localparam int ROWS_CAP  = 15;

// Running copy of the checker state; predicts one verdict word per candidate
// and matches the verdict words that come out of the block.
class verdict_board;
    logic [4:0]  order_reg;
    logic [4:0]  cols_reg;
    logic [3:0]  rows_reg;
    logic        diag_reg;

    logic [15:0] row_mask;
    logic [15:0] col_mask [16];
    logic [15:0] main_mask;
    logic [15:0] sec_mask;
    int          col_cnt;
    int          row_cnt;
    int          cell_cnt;
    logic [2:0]  first_code;
    int          first_idx;

    plr_pkg::t_out_word verdicts_due[$];
    int          mismatches;

    function new();
        order_reg  = plr_pkg::RST_SQUARE_ORDER;
        cols_reg   = plr_pkg::RST_COLUMNS_IN_USE;
        rows_reg   = plr_pkg::RST_ROWS_IN_USE;
        diag_reg   = 1'b0;
        mismatches = 0;
        reseed();
    endfunction

    function int order();
        if (order_reg < 2) return 2;
        if (order_reg > ORDER_CAP) return ORDER_CAP;
        return order_reg;
    endfunction

    function int columns();
        if (cols_reg < 1) return 1;
        if (cols_reg > order()) return order();
        return cols_reg;
    endfunction

    function int rows();
        if (rows_reg < 1) return 1;
        if (rows_reg > ROWS_CAP) return ROWS_CAP;
        return rows_reg;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    // identity row seeds the columns, the corner symbols seed the diagonals
    function void reseed();
        int c;
        row_mask = '0;
        for (c = 0; c < 16; c++) begin
            col_mask[c] = 16'h0001 << c;
        end
        main_mask  = 16'h0001;
        sec_mask   = 16'h0001 << (order() - 1);
        col_cnt    = 0;
        row_cnt    = 0;
        cell_cnt   = 0;
        first_code = plr_pkg::FAIL_NONE;
        first_idx  = 0;
    endfunction

    // any write restarts the candidate
    function void set_reg(logic [1:0] idx, logic [4:0] data);
        case (idx)
            plr_pkg::REG_SQUARE_ORDER:   order_reg = data;
            plr_pkg::REG_COLUMNS_IN_USE: cols_reg  = data;
            plr_pkg::REG_ROWS_IN_USE:    rows_reg  = data[3:0];
            plr_pkg::REG_DIAGONAL_MODE:  diag_reg  = data[0];
            default: ;
        endcase
        reseed();
    endfunction

    function void take_cell(plr_pkg::t_in_word w);
        int          n;
        int          cols;
        int          span;
        int          here;
        int          c;
        int          r;
        logic [15:0] sym;
        logic        on_main;
        logic        on_sec;
        logic [2:0]  code;
        plr_pkg::t_out_word v;
        n    = order();
        cols = columns();
        span = rows() * cols;
        here = cell_cnt;
        if (here < span) begin
            sym     = 16'h0001 << w.cell_value;
            c       = col_cnt % 16;
            r       = row_cnt + 1;
            on_main = diag_reg && (c == r);
            on_sec  = diag_reg && (r <= n - 1) && (c == n - 1 - r);
            code    = plr_pkg::FAIL_NONE;
            if ((row_mask & sym) != 0) begin
                code = plr_pkg::FAIL_ROW;
            end else if ((col_mask[c] & sym) != 0) begin
                code = plr_pkg::FAIL_COLUMN;
            end else if (on_main && (main_mask & sym) != 0) begin
                code = plr_pkg::FAIL_MAIN;
            end else if (on_sec && (sec_mask & sym) != 0) begin
                code = plr_pkg::FAIL_SEC;
            end
            if (code != plr_pkg::FAIL_NONE && first_code == plr_pkg::FAIL_NONE) begin
                first_code = code;
                first_idx  = here & 255;
            end
            row_mask    = row_mask | sym;
            col_mask[c] = col_mask[c] | sym;
            if (on_main) main_mask = main_mask | sym;
            if (on_sec) sec_mask = sec_mask | sym;
            if (col_cnt + 1 >= cols) begin
                col_cnt  = 0;
                row_cnt  = (row_cnt + 1) & 15;
                row_mask = '0;
            end else begin
                col_cnt = col_cnt + 1;
            end
        end
        if (cell_cnt < 255) cell_cnt = cell_cnt + 1;
        if (w.last_cell) begin
            if (first_code == plr_pkg::FAIL_NONE && cell_cnt != span) begin
                first_code = plr_pkg::FAIL_COUNT;
                first_idx  = here & 255;
            end
            v.candidate_valid  = (first_code == plr_pkg::FAIL_NONE);
            v.failure_code     = first_code;
            v.failure_position = (first_code == plr_pkg::FAIL_NONE) ? 8'd0 : first_idx[7:0];
            verdicts_due.insert(verdicts_due.size(), v);
            reseed();
        end
    endfunction

    function void match_verdict(plr_pkg::t_out_word got);
        plr_pkg::t_out_word want;
        if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: verdict word with none pending: valid=%0d code=%0d pos=%0d",
                         $realtime, got.candidate_valid, got.failure_code,
                         got.failure_position);
            return;
        end
        want = verdicts_due.pop_front();
        if (got.candidate_valid !== want.candidate_valid ||
            got.failure_code !== want.failure_code ||
            got.failure_position !== want.failure_position) begin
            mismatches++;
            // valid/code/position
            if (mismatches <= 10)
                $display("%0t: verdict mismatch: want %0d/%0d/%0d, got %0d/%0d/%0d",
                         $realtime, want.candidate_valid, want.failure_code,
                         want.failure_position, got.candidate_valid, got.failure_code,
                         got.failure_position);
        end
    endfunction
endclass

module partial_latin_rows_checker_tb;
    import plr_pkg::*;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_idx   = REG_SQUARE_ORDER;
    logic [4:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;
    logic       i_out_stall = 1'b0;

    verdict_board verdicts = new();

    // sender / receiver idle rates; the receiver side is updated by NBA only
    int   src_idle_pct = 0;
    int   sink_pct     = 0;
    logic sink_hold    = 1'b1;
    // verdicts still owed, as of the previous edge
    int   due_count    = 0;
    int   items_sent   = 0;

    // candidate under construction and the Latin square it is cut from
    int   cell_run[$];
    int   sq    [16][16];
    int   perm  [16];
    int   shift [16];

    partial_latin_rows_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case a word is lost or the handshake hangs
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stall, forced low while settings change
    always @(posedge i_clk) begin
        if (sink_hold || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_pct);
        end
    end

    // both handshakes are sampled on the edge that completes them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) verdicts.take_cell(i_in_word);
            if (o_out_valid && !i_out_stall) verdicts.match_verdict(o_out_word);
        end
        due_count <= verdicts.pending();
    end

    // one cell word; returns on the edge where it is taken
    task automatic send_cell(input int val, input bit last);
        t_in_word w;
        w.cell_value = val[3:0];
        w.last_cell  = last;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_candidate();
        int k;
        for (k = 0; k < cell_run.size(); k++) begin
            send_cell(cell_run[k], k == cell_run.size() - 1);
        end
        items_sent += cell_run.size();
    endtask

    // sender goes quiet until every verdict word is back
    task automatic hold_for_verdicts();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
    endtask

    // drain, then freeze the receiver and let the pipe empty of non-last cells
    task automatic settle();
        hold_for_verdicts();
        sink_hold <= 1'b1;
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        verdicts.set_reg(idx, data);
    endtask

    // unused upper data bits are randomized; the block must ignore them
    task automatic program_setup(input int ord, input int cols, input int rows, input int diag);
        logic [4:0] junk;
        junk = 5'($urandom);
        write_reg(REG_SQUARE_ORDER, ord[4:0]);
        write_reg(REG_COLUMNS_IN_USE, cols[4:0]);
        write_reg(REG_ROWS_IN_USE, {junk[4], rows[3:0]});
        write_reg(REG_DIAGONAL_MODE, {junk[3:0], diag[0]});
        i_cfg_we <= 1'b0;
    endtask

    function automatic void shuffle(ref int a [16], input int lo, input int hi);
        int i;
        int j;
        int t;
        for (i = hi; i > lo; i--) begin
            j    = $urandom_range(lo, i);
            t    = a[i];
            a[i] = a[j];
            a[j] = t;
        end
    endfunction

    // Latin square with the identity in row 0. Orders 5, 7, 11, 13 in diagonal
    // mode may take the 2r+c square, which also keeps both diagonals distinct.
    // Otherwise a random cyclic square, conjugated by one permutation applied to
    // columns and symbols alike so the identity row survives.
    function automatic void fill_square(input int n);
        int r;
        int c;
        if (verdicts.diag_reg && (n == 5 || n == 7 || n == 11 || n == 13) &&
            $urandom_range(1)) begin
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                    sq[r][c] = (2 * r + c) % n;
        end else begin
            for (c = 0; c < n; c++) begin
                perm[c]  = c;
                shift[c] = c;
            end
            shuffle(perm, 0, n - 1);
            shuffle(shift, 1, n - 1);
            for (r = 0; r < n; r++)
                for (c = 0; c < n; c++)
                    sq[r][perm[c]] = perm[(c + shift[r]) % n];
        end
    endfunction

    // mostly clean candidates, then single bad cells, short, long and noise runs
    function automatic void build_candidate();
        int n;
        int cols;
        int rows;
        int span;
        int pick;
        int len;
        int r;
        int c;
        n    = verdicts.order();
        cols = verdicts.columns();
        rows = verdicts.rows();
        span = rows * cols;
        fill_square(n);
        cell_run.delete();
        // rows past N-1 wrap back and are bound to repeat a column
        for (r = 1; r <= rows; r++)
            for (c = 0; c < cols; c++)
                cell_run.insert(cell_run.size(), sq[r % n][c]);
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 70) begin
            cell_run[$urandom_range(span - 1)] = $urandom_range(15);
        end else if (pick >= 70 && pick < 80) begin
            if (span > 1) begin
                len = $urandom_range(1, span - 1);
                while (cell_run.size() > len) void'(cell_run.pop_back());
            end
        end else if (pick >= 80 && pick < 88) begin
            repeat ($urandom_range(1, 4)) cell_run.insert(cell_run.size(), $urandom_range(15));
        end else if (pick >= 88) begin
            cell_run.delete();
            len = span + $urandom_range(4) - 2;
            if (len < 1) len = 1;
            repeat (len) cell_run.insert(cell_run.size(), $urandom_range(15));
        end
    endfunction

    // settings for one block of candidates; out-of-range values now and then
    task automatic choose_setup(input int ph, input int blk);
        int o;
        int c;
        int r;
        int ne;
        int sel;
        if (blk == 0) begin
            // largest square; the full 15-row stream only once
            program_setup(16, 16, (ph == 0) ? 15 : 1, 1);
        end else if (blk == 1) begin
            program_setup(2, 1, 1, 0);
        end else begin
            sel = $urandom_range(99);
            if (sel < 8) o = $urandom_range(1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
            else o = $urandom_range(2, 16);
            ne  = (o < 2) ? 2 : (o > 16) ? 16 : o;
            sel = $urandom_range(99);
            if (sel < 10) c = $urandom_range(1) ? 0 : $urandom_range(ne + 1, 31);
            else c = $urandom_range(1, ne);
            sel = $urandom_range(99);
            if (sel < 8) r = 0;
            else if (sel < 18) r = $urandom_range(5, 15);
            else r = $urandom_range(1, (ne > 5) ? 4 : ne - 1);
            program_setup(o, c, r, $urandom_range(1));
        end
    endtask

    initial begin
        int ph;
        int blk;
        int phase_start;
        int span;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // reset settings (order 10, 10 columns, 2 rows): one lone cell is short
        cell_run = '{5};
        send_candidate();
        settle();

        // order 4, full rows, one row, diagonals on
        program_setup(4, 4, 1, 1);
        cell_run = '{1, 3, 0, 2};        // clean row
        send_candidate();
        cell_run = '{1, 1};              // row and column hit on one cell: row wins
        send_candidate();
        cell_run = '{0};                 // column hit, then short; column reported
        send_candidate();
        cell_run = '{1, 0};              // main diagonal repeat of seeded 0
        send_candidate();
        cell_run = '{1, 2, 3};           // secondary diagonal repeat of seeded 3
        send_candidate();
        cell_run = '{3, 2, 15, 0};       // symbol above the order, still clean
        send_candidate();
        cell_run = '{1, 3, 0, 2, 9, 9};  // surplus cells, count error on last
        send_candidate();

        // ---- random part: three idle profiles ----
        for (ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 46 : 0;
            sink_pct    <= (ph == 0) ? 46 : (ph == 1) ? 14 : 0;
            phase_start  = items_sent;
            blk          = 0;
            while (items_sent - phase_start < 500) begin
                settle();
                choose_setup(ph, blk);
                sink_hold <= 1'b0;
                span = verdicts.rows() * verdicts.columns();
                if (ph == 2 && blk == 1) begin
                    // one cell expected, 257 sent: the cell count saturates
                    cell_run.delete();
                    repeat (257) cell_run.insert(cell_run.size(), $urandom_range(15));
                    send_candidate();
                end else begin
                    repeat ((span > 100) ? 1 : $urandom_range(2, 6)) begin
                        build_candidate();
                        send_candidate();
                        if ($urandom_range(5) == 0) hold_for_verdicts();
                    end
                end
                blk++;
            end
        end

        // ---- wind down ----
        hold_for_verdicts();
        repeat (8) @(posedge i_clk);
        if (verdicts.mismatches == 0 && verdicts.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
